// ===== sv/assert_macros.svh =====
// Assertion shorthands shared by the palette indexer RTL.
// Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CPI_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define CPI_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/cpi_pkg.sv =====
`default_nettype none

package cpi_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int MAX_DIMENSION = 4096;

  localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

  localparam int CHAN_W      = 8;
  localparam int COLOUR_W    = 3 * CHAN_W;
  localparam int DIM_W       = 13;
  localparam int POS_W       = 12;
  localparam int INDEX_OUT_W = 8;
  localparam int CFG_ADDR_W  = 1;

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // Lookup request walking the cell row.
  typedef struct packed {
    logic                vld;
    logic [COLOUR_W-1:0] colour;
    logic                hit;
    logic                is_new;
    logic [IDX_W-1:0]    idx;
  } cpi_tok_t;

  // Raster position of one pixel.
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             size_error;
  } cpi_pos_t;

endpackage

`default_nettype wire

// ===== sv/cpi_cell.sv =====
`default_nettype none

module cpi_cell import cpi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire logic [CNT_W-1:0] used,
  input  wire cpi_tok_t         tok_i,
  output cpi_tok_t              tok_o
);

  logic [COLOUR_W-1:0] entry_r;
  cpi_tok_t            tok_r;
  cpi_tok_t            tok_nxt;
  logic                live;
  logic                match;
  logic                insert;

  always_comb begin
    live   = CNT_W'(cell_idx) < used;
    match  = tok_i.vld && !tok_i.hit && live && (entry_r == tok_i.colour);
    // first free slot takes a colour that missed every live entry ahead
    insert = tok_i.vld && !tok_i.hit && (CNT_W'(cell_idx) == used);
    tok_nxt = tok_i;
    if (match || insert) begin
      tok_nxt.hit    = 1'b1;
      tok_nxt.idx    = cell_idx;
      tok_nxt.is_new = insert;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      entry_r <= tok_i.colour;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

// ===== sv/cpi_chain.sv =====
`default_nettype none

module cpi_chain import cpi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CNT_W-1:0] used,
  input  wire cpi_tok_t         tok_i,
  output cpi_tok_t              tok_o
);

  cpi_tok_t tok_w [0:PALETTE_DEPTH];

  assign tok_w[0] = tok_i;

  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    cpi_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(k)),
      .used     (used),
      .tok_i    (tok_w[k]),
      .tok_o    (tok_w[k+1])
    );
  end

  assign tok_o = tok_w[PALETTE_DEPTH];

endmodule

`default_nettype wire

// ===== sv/cpi_pos.sv =====
`default_nettype none

module cpi_pos import cpi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             last,
  input  wire logic [DIM_W-1:0] width,
  input  wire logic [DIM_W-1:0] height,
  output cpi_pos_t              pos
);

  logic [POS_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end
    return r;
  endfunction

  always_comb begin
    w       = clamp_dim(width);
    h       = clamp_dim(height);
    col_nxt = col_r;
    row_nxt = row_r;
    pos     = '0;
    if (row_r >= h) begin
      // past the frame: flag it, report origin, hold counters
      pos.size_error = 1'b1;
    end else begin
      pos.row    = row_r[POS_W-1:0];
      pos.column = col_r;
      if (last && !((row_r == h - DIM_W'(1)) && (DIM_W'(col_r) == w - DIM_W'(1)))) begin
        pos.size_error = 1'b1;
      end
      if (DIM_W'(col_r) + DIM_W'(1) >= w) begin
        col_nxt = '0;
        row_nxt = row_r + DIM_W'(1);
      end else begin
        col_nxt = col_r + POS_W'(1);
      end
    end
    if (last) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (adv) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/colour_palette_indexer_top.sv =====
// Palette indexer: each RGB pixel is looked up in a palette held in a row of
// PALETTE_DEPTH cells, one colour per cell. A pixel enters the row as a request
// and moves one cell per clock; the cell holding its colour tags it with that
// index, or the first free cell stores it and tags it new. With the palette
// full the result carries index 0 and palette_overflow. One pixel is in the
// row at a time: the next pixel is accepted only once the previous result has
// moved from the pending register into the output register, which waits while
// the output is stalled. The raster position and size error are computed on
// acceptance from the image_width and image_height registers; a pixel with
// tlast closes the image and empties the palette. Write configuration only
// between images.
`default_nettype none
`include "assert_macros.svh"

module colour_palette_indexer_top import cpi_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [23:0]           in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [31:0]                out_tdata,  // colour_index[7:0], row[19:8], column[31:20]
  output logic [2:0]                 out_tuser,  // is_new[0], palette_overflow[1], size_error[2]
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [DIM_W-1:0]      cfg_wdata
);

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic             accept;
  logic             move;
  cpi_tok_t         tok_in;
  cpi_tok_t         tok_out;
  cpi_pos_t         pos_cur;

  logic             busy_r;
  logic             pend_vld_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             pend_new_r;
  logic             pend_ovf_r;
  cpi_pos_t         pos_hold_r;
  logic             last_hold_r;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic             out_tvalid_r;
  logic [31:0]      out_tdata_r;
  logic [2:0]       out_tuser_r;

  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;
  assign move      = pend_vld_r && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  always_comb begin
    tok_in        = '0;
    tok_in.vld    = accept;
    tok_in.colour = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
  end

  cpi_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .used  (used_r),
    .tok_i (tok_in),
    .tok_o (tok_out)
  );

  cpi_pos u_pos (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (accept),
    .last   (in_tlast),
    .width  (width_r),
    .height (height_r),
    .pos    (pos_cur)
  );

  always_comb begin
    used_nxt = used_r;
    if (tok_out.vld) begin
      if (last_hold_r) begin
        used_nxt = '0;
      end else if (tok_out.is_new) begin
        used_nxt = used_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
      used_r       <= '0;
    end else begin
      used_r <= used_nxt;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (move) begin
        busy_r <= 1'b0;
      end
      if (tok_out.vld) begin
        pend_vld_r <= 1'b1;
      end else if (move) begin
        pend_vld_r <= 1'b0;
      end
      if (move) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload: hold position with the pixel, catch the row's answer, then load output
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_hold_r  <= pos_cur;
      last_hold_r <= in_tlast;
    end
    if (tok_out.vld) begin
      pend_idx_r <= tok_out.hit ? tok_out.idx : '0;
      pend_new_r <= tok_out.is_new;
      pend_ovf_r <= !tok_out.hit;
    end
    if (move) begin
      out_tdata_r <= {pos_hold_r.column, pos_hold_r.row, INDEX_OUT_W'(pend_idx_r)};
      out_tuser_r <= {pos_hold_r.size_error, pend_ovf_r, pend_new_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `CPI_ASSERT_IMPL(a_exit_while_busy, tok_out.vld, busy_r && !pend_vld_r, "request left cell row with no pixel in flight")
  `CPI_ASSERT_IMPL(a_overflow_when_full, tok_out.vld && !tok_out.hit, used_r == CNT_W'(PALETTE_DEPTH), "miss without insert while palette had room")
  `CPI_ASSERT_IMPL(a_used_bound, 1'b1, used_r <= CNT_W'(PALETTE_DEPTH), "palette fill count past depth")
  `CPI_ASSERT_NEXT(a_one_in_flight, accept, !in_tready, "second pixel accepted while first in flight")

endmodule

`default_nettype wire

// ===== bench/colour_palette_indexer_top_tb.sv =====
`default_nettype none

module colour_palette_indexer_top_tb import cpi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [INDEX_OUT_W-1:0] colour_index;
    logic                   is_new;
    logic                   palette_overflow;
    logic [POS_W-1:0]       row;
    logic [POS_W-1:0]       column;
    logic                   size_error;
  } pixel_result_t;

  typedef enum logic {ROW_PIXEL, ROW_REG} script_kind_t;

  typedef struct packed {
    script_kind_t          kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [DIM_W-1:0]      value;
    logic [COLOUR_W-1:0]   colour;
    logic                  last;
    logic                  typed;
    pixel_result_t         want;
  } script_row_t;

  localparam pixel_result_t NO_CHECK = '0;

  // Rows with typed results: reset state, single-pixel images, pixels past the image,
  // last at the wrong position.
  localparam script_row_t SCRIPT [33] = '{
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h000000, 1'b1, 1'b1,
      '{8'd0, 1'b1, 1'b0, 12'd0, 12'd0, 1'b0}},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'hFFFFFF, 1'b1, 1'b1,
      '{8'd0, 1'b1, 1'b0, 12'd0, 12'd0, 1'b0}},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'hFFFFFF, 1'b0, 1'b1,
      '{8'd0, 1'b1, 1'b0, 12'd0, 12'd0, 1'b0}},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'hFFFFFF, 1'b0, 1'b1,
      '{8'd0, 1'b0, 1'b0, 12'd0, 12'd0, 1'b1}},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h000000, 1'b1, 1'b1,
      '{8'd1, 1'b1, 1'b0, 12'd0, 12'd0, 1'b1}},
    '{ROW_REG,   CFG_IMAGE_WIDTH,  13'd0, 24'h0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_REG,   CFG_IMAGE_HEIGHT, 13'd0, 24'h0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'hAA55AA, 1'b1, 1'b1,
      '{8'd0, 1'b1, 1'b0, 12'd0, 12'd0, 1'b0}},
    '{ROW_REG,   CFG_IMAGE_WIDTH,  13'd3, 24'h0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_REG,   CFG_IMAGE_HEIGHT, 13'd2, 24'h0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h123456, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h654321, 1'b1, 1'b1,
      '{8'd1, 1'b1, 1'b0, 12'd0, 12'd1, 1'b1}},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h123456, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h654321, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h123456, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h0000FF, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h00FF00, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'hFF0000, 1'b1, 1'b0, NO_CHECK},
    '{ROW_REG,   CFG_IMAGE_WIDTH,  13'd4, 24'h0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_REG,   CFG_IMAGE_HEIGHT, 13'd3, 24'h0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h800000, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h008000, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h000080, 1'b0, 1'b0, NO_CHECK},
    // shrink the width below the current column mid-image
    '{ROW_REG,   CFG_IMAGE_WIDTH,  13'd2, 24'h0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h7F7F7F, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h800000, 1'b1, 1'b0, NO_CHECK},
    '{ROW_REG,   CFG_IMAGE_WIDTH,  13'd8191, 24'h0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_REG,   CFG_IMAGE_HEIGHT, 13'd8191, 24'h0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h010203, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'h010203, 1'b1, 1'b1,
      '{8'd0, 1'b0, 1'b0, 12'd0, 12'd1, 1'b1}},
    '{ROW_REG,   CFG_IMAGE_WIDTH,  13'd4096, 24'h0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_REG,   CFG_IMAGE_HEIGHT, 13'd1, 24'h0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_PIXEL, CFG_IMAGE_WIDTH, 13'd0, 24'hFEDCBA, 1'b1, 1'b0, NO_CHECK}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;  // colour_index[7:0], row[19:8], column[31:20]
  logic [2:0]            out_tuser;  // is_new[0], palette_overflow[1], size_error[2]
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [DIM_W-1:0]      cfg_wdata;

  colour_palette_indexer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // palette and raster model
  logic [COLOUR_W-1:0] palette_mem [PALETTE_DEPTH];
  int unsigned         palette_count;
  int unsigned         column_pos;
  int unsigned         row_pos;
  logic [DIM_W-1:0]    width_reg;
  logic [DIM_W-1:0]    height_reg;

  pixel_result_t queued_lookups [$];
  pixel_result_t predicted;
  pixel_result_t got;
  pixel_result_t want;

  logic          typed_armed;
  pixel_result_t typed_result;

  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          pixels_sent;
  int          mismatches;
  int unsigned cycle_count;
  logic [DIM_W-1:0] set_width;
  logic [DIM_W-1:0] set_height;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned active_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (32'(v) > MAX_DIMENSION) return MAX_DIMENSION;
    return 32'(v);
  endfunction

  function automatic pixel_result_t index_pixel(logic [COLOUR_W-1:0] colour, logic last);
    pixel_result_t res;
    int unsigned   w;
    int unsigned   h;
    bit            found;
    res = '0;
    w = active_dim(width_reg);
    h = active_dim(height_reg);
    found = 1'b0;
    for (int unsigned i = 0; i < palette_count; i++) begin
      if (!found && palette_mem[i] == colour) begin
        res.colour_index = i[INDEX_OUT_W-1:0];
        found = 1'b1;
      end
    end
    if (!found) begin
      if (palette_count < PALETTE_DEPTH) begin
        palette_mem[palette_count] = colour;
        res.colour_index = palette_count[INDEX_OUT_W-1:0];
        res.is_new = 1'b1;
        palette_count++;
      end else begin
        res.palette_overflow = 1'b1;
      end
    end
    if (row_pos >= h) begin
      // past the image: position reads zero and the counters hold
      res.size_error = 1'b1;
    end else begin
      res.row = row_pos[POS_W-1:0];
      res.column = column_pos[POS_W-1:0];
      if (last && !(row_pos == h - 1 && column_pos == w - 1)) res.size_error = 1'b1;
      if (column_pos + 1 >= w) begin
        column_pos = 0;
        row_pos++;
      end else begin
        column_pos++;
      end
    end
    if (last) begin
      palette_count = 0;
      column_pos = 0;
      row_pos = 0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      palette_count = 0;
      column_pos = 0;
      row_pos = 0;
      width_reg = DIM_W'(1);
      height_reg = DIM_W'(1);
    end else begin
      if (in_tvalid && in_tready) begin
        predicted = index_pixel({in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]}, in_tlast);
        if (typed_armed) predicted = typed_result;
        queued_lookups.push_back(predicted);
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_IMAGE_WIDTH:  width_reg = cfg_wdata;
          CFG_IMAGE_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  task automatic report_mismatch(string what, pixel_result_t exp_r, pixel_result_t act_r);
    mismatches++;
    if (mismatches <= 10)
      $display("%s at cycle %0d: expected idx=%0d new=%0b ovf=%0b row=%0d col=%0d err=%0b, %s",
               what, cycle_count, exp_r.colour_index, exp_r.is_new, exp_r.palette_overflow,
               exp_r.row, exp_r.column, exp_r.size_error,
               $sformatf("got idx=%0d new=%0b ovf=%0b row=%0d col=%0d err=%0b",
                         act_r.colour_index, act_r.is_new, act_r.palette_overflow,
                         act_r.row, act_r.column, act_r.size_error));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.colour_index     = out_tdata[7:0];
      got.row              = out_tdata[19:8];
      got.column           = out_tdata[31:20];
      got.is_new           = out_tuser[0];
      got.palette_overflow = out_tuser[1];
      got.size_error       = out_tuser[2];
      if (queued_lookups.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = queued_lookups.pop_front();
        if (got !== want) report_mismatch("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("colour_palette_indexer_top verification failed");
      $finish;
    end
  end

  task automatic send_pixel(logic [COLOUR_W-1:0] colour, logic last, logic typed,
                            pixel_result_t typed_want);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tdata     <= {colour[7:0], colour[15:8], colour[23:16]};
    in_tlast     <= last;
    typed_armed  <= typed;
    typed_result <= typed_want;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  // hold off until every queued lookup has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (queued_lookups.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [DIM_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (addr == CFG_IMAGE_WIDTH) set_width = value;
    else set_height = value;
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? 13'd8191 : 13'd4096;
      2:       return 13'd1;
      3:       return DIM_W'($urandom_range(MAX_DIMENSION + 1, 8191));
      default: return DIM_W'($urandom_range(1, 6));
    endcase
  endfunction

  // Full palette: 256 new colours, a few misses that overflow, then revisits.
  task automatic overflow_image();
    logic [COLOUR_W-1:0] base;
    logic [COLOUR_W-1:0] colour;
    drain();
    write_reg(CFG_IMAGE_WIDTH, 13'd17);
    write_reg(CFG_IMAGE_HEIGHT, 13'd16);
    base = COLOUR_W'($urandom);
    for (int i = 0; i < 272; i++) begin
      if (i < 262) colour = base + COLOUR_W'(i) * 24'h010101;
      else colour = base + COLOUR_W'($urandom_range(0, 261)) * 24'h010101;
      send_pixel(colour, i == 271, 1'b0, NO_CHECK);
    end
  endtask

  task automatic random_image();
    logic [COLOUR_W-1:0] pool [6];
    logic [COLOUR_W-1:0] colour;
    int unsigned         area;
    int                  n;
    int                  mode;
    bit                  with_last;
    if ($urandom_range(0, 9) < 4) begin
      drain();
      write_reg(CFG_IMAGE_WIDTH, pick_dim());
      write_reg(CFG_IMAGE_HEIGHT, pick_dim());
    end
    foreach (pool[k]) pool[k] = COLOUR_W'($urandom);
    area = active_dim(set_width) * active_dim(set_height);
    mode = $urandom_range(0, 99);
    with_last = 1'b1;
    if (area > 40) begin
      // frame over 40 pixels: a short burst, usually closed early
      n = $urandom_range(1, 6);
      with_last = (mode < 85);
    end else if (mode < 72) begin
      n = area;
    end else if (mode < 82) begin
      n = $urandom_range(1, area);
    end else if (mode < 92) begin
      n = area + $urandom_range(1, 3);
    end else begin
      // leave the frame open so the next one starts mid-raster
      n = $urandom_range(1, area);
      with_last = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 65) colour = pool[$urandom_range(0, 5)];
      else colour = COLOUR_W'($urandom);
      send_pixel(colour, with_last && (i == n - 1), 1'b0, NO_CHECK);
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_tvalid          <= 1'b0;
    in_tdata           <= '0;
    in_tlast           <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_addr           <= CFG_IMAGE_WIDTH;
    cfg_wdata          <= '0;
    out_tready         <= 1'b0;
    typed_armed        <= 1'b0;
    typed_result       <= '0;
    cycle_count        <= 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    pixels_sent        = 0;
    mismatches         = 0;
    set_width          = DIM_W'(1);
    set_height         = DIM_W'(1);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(SCRIPT); i++) begin
      if (SCRIPT[i].kind == ROW_REG) begin
        drain();
        write_reg(SCRIPT[i].addr, SCRIPT[i].value);
      end else begin
        send_pixel(SCRIPT[i].colour, SCRIPT[i].last, SCRIPT[i].typed, SCRIPT[i].want);
      end
    end

    overflow_image();

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
        default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
      endcase
      n_start: begin
        int target;
        target = pixels_sent + 260;
        while (pixels_sent < target) random_image();
      end
    end

    drain();
    repeat (PALETTE_DEPTH + 16) @(posedge clk);
    if (mismatches == 0 && queued_lookups.size() == 0) begin
      $display("colour_palette_indexer_top verification clean");
    end else begin
      $display("colour_palette_indexer_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== colour_palette_indexer_top.f =====
+incdir+sv
sv/cpi_pkg.sv
sv/cpi_cell.sv
sv/cpi_chain.sv
sv/cpi_pos.sv
sv/colour_palette_indexer_top.sv
bench/colour_palette_indexer_top_tb.sv
